// File: rtl/kprcd_pkg.sv
`default_nettype none

package kprcd_pkg;

   // report kinds
   localparam logic [7:0] KIND_MACRO     = 8'h01;
   localparam logic [7:0] KIND_MODE_SOFT = 8'h02;

   // key groups
   localparam int MACRO_KEYS     = 18;
   localparam int MODE_KEYS      = 4;
   localparam int SOFT_KEYS      = 5;
   localparam int IDX_W          = $clog2(MACRO_KEYS);
   localparam int MODE_IDX_W     = $clog2(MODE_KEYS);
   localparam int SOFT_IDX_W     = $clog2(SOFT_KEYS);
   localparam int MACRO_LAST     = MACRO_KEYS - 1;
   localparam int MODE_SOFT_LAST = MODE_KEYS + SOFT_KEYS - 1;

   // macro key codes
   localparam logic [7:0] MACRO_CODE_LOW  = 8'h3a;
   localparam logic [7:0] MACRO_CODE_HIGH = 8'h1e;
   localparam int         MACRO_LOW_KEYS  = 12;

   // register file
   localparam int         CSR_IDX_W         = 2;
   localparam logic [1:0] CSR_MACRO_BASE    = 2'd0;
   localparam logic [1:0] CSR_MODE_BASE     = 2'd1;
   localparam logic [1:0] CSR_SOFT_BASE     = 2'd2;
   localparam logic [7:0] MACRO_BASE_RESET  = 8'd167;
   localparam logic [7:0] MODE_BASE_RESET   = 8'd185;
   localparam logic [7:0] SOFT_BASE_RESET   = 8'd189;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN
   } state_type;

   // sequencer to datapath
   typedef struct packed {
      logic             capture;
      logic             macro_sel;
      logic             toggle;
      logic [IDX_W-1:0] idx;
   } seq_ctrl_type;

   // key unit to sequencer
   typedef struct packed {
      logic       fresh;
      logic       held;
      logic [7:0] code;
   } key_result_type;

   // scan code of macro key i
   function automatic logic [7:0] macro_code(input logic [IDX_W-1:0] idx);
      logic [7:0] wide_idx;
      wide_idx = 8'(idx);
      if (wide_idx < 8'(MACRO_LOW_KEYS)) begin
         return MACRO_CODE_LOW + wide_idx;
      end
      return MACRO_CODE_HIGH + wide_idx - 8'(MACRO_LOW_KEYS);
   endfunction

endpackage

`default_nettype wire

// File: rtl/kprcd_key_unit.sv
`default_nettype none

module kprcd_key_unit (
   input  wire logic                          macro_sel,
   input  wire logic [kprcd_pkg::IDX_W-1:0]   idx,
   input  wire logic [63:0]                   report,
   input  wire logic [7:0]                    macro_base,
   input  wire logic [7:0]                    mode_base,
   input  wire logic [7:0]                    soft_base,
   input  wire logic [kprcd_pkg::MACRO_KEYS-1:0] macro_pressed,
   input  wire logic [kprcd_pkg::MODE_KEYS-1:0]  mode_pressed,
   input  wire logic [kprcd_pkg::SOFT_KEYS-1:0]  soft_pressed,
   output kprcd_pkg::key_result_type          result
);

   logic [7:0] code;
   logic [7:0] b [1:8];
   logic [kprcd_pkg::MODE_IDX_W-1:0] mode_idx;
   logic [kprcd_pkg::SOFT_IDX_W-1:0] soft_idx;
   logic       fresh_pair;

   // split report into bytes one to eight
   always_comb begin
      for (int n = 1; n <= 8; n++) begin
         b[n] = report[8*(n-1) +: 8];
      end
   end

   assign code     = kprcd_pkg::macro_code(idx);
   assign mode_idx = idx[kprcd_pkg::MODE_IDX_W-1:0];
   assign soft_idx = kprcd_pkg::SOFT_IDX_W'(idx - kprcd_pkg::IDX_W'(kprcd_pkg::MODE_KEYS));

   // fixed bit of the mode/soft report for the current key
   always_comb begin
      case (idx)
         5'd0:    fresh_pair = b[6][0];
         5'd1:    fresh_pair = b[7][1];
         5'd2:    fresh_pair = b[8][2];
         5'd3:    fresh_pair = b[7][6];
         5'd4:    fresh_pair = b[8][7];
         5'd5:    fresh_pair = b[2][7];
         5'd6:    fresh_pair = b[3][7];
         5'd7:    fresh_pair = b[4][7];
         5'd8:    fresh_pair = b[5][7];
         default: fresh_pair = 1'b0;
      endcase
   end

   // one key per cycle: compare, held-state pick and code add
   always_comb begin
      result = '0;
      if (macro_sel) begin
         result.fresh = (b[1] == code) || (b[2] == code) || (b[3] == code) ||
                        (b[4] == code) || (b[5] == code);
         result.held  = (idx < kprcd_pkg::IDX_W'(kprcd_pkg::MACRO_KEYS)) ?
                        macro_pressed[idx] : 1'b0;
         result.code  = macro_base + 8'(idx);
      end else if (idx < kprcd_pkg::IDX_W'(kprcd_pkg::MODE_KEYS)) begin
         result.fresh = fresh_pair;
         result.held  = mode_pressed[mode_idx];
         result.code  = mode_base + 8'(mode_idx);
      end else begin
         result.fresh = fresh_pair;
         result.held  = (soft_idx < kprcd_pkg::SOFT_IDX_W'(kprcd_pkg::SOFT_KEYS)) ?
                        soft_pressed[soft_idx] : 1'b0;
         result.code  = soft_base + 8'(soft_idx);
      end
   end

endmodule

`default_nettype wire

// File: rtl/kprcd_seq.sv
`default_nettype none

module kprcd_seq (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_tvalid,
   output logic                            req_tready,
   input  wire logic [7:0]                 req_kind,
   input  wire kprcd_pkg::key_result_type  result,
   output kprcd_pkg::seq_ctrl_type         ctrl,
   output logic                            rsp_tvalid,
   input  wire logic                       rsp_tready,
   output logic [7:0]                      rsp_code,
   output logic                            rsp_down,
   output logic                            rsp_last
);

   kprcd_pkg::state_type state_ff, state_in;
   logic [kprcd_pkg::IDX_W-1:0] idx_ff, idx_in;
   logic macro_ff, macro_in;
   logic hold_valid_ff, hold_valid_in;
   logic [7:0] hold_code_ff, hold_code_in;
   logic hold_down_ff, hold_down_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_code_ff, rsp_code_in;
   logic rsp_down_ff, rsp_down_in;
   logic rsp_last_ff, rsp_last_in;
   logic out_free;
   logic changed;
   logic scan_end;
   logic accept;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign changed    = result.fresh != result.held;
   assign scan_end   = macro_ff ? (idx_ff == kprcd_pkg::IDX_W'(kprcd_pkg::MACRO_LAST)) :
                                  (idx_ff == kprcd_pkg::IDX_W'(kprcd_pkg::MODE_SOFT_LAST));
   assign req_tready = (state_ff == kprcd_pkg::ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   // state and word registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= kprcd_pkg::ST_IDLE;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      idx_ff       <= idx_in;
      macro_ff     <= macro_in;
      hold_code_ff <= hold_code_in;
      hold_down_ff <= hold_down_in;
      rsp_code_ff  <= rsp_code_in;
      rsp_down_ff  <= rsp_down_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // sequencer: one key a cycle unless stalled; held event waits for next or end
   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      macro_in      = macro_ff;
      hold_valid_in = hold_valid_ff;
      hold_code_in  = hold_code_ff;
      hold_down_in  = hold_down_ff;
      rsp_valid_in  = rsp_tready ? 1'b0 : rsp_valid_ff;
      rsp_code_in   = rsp_code_ff;
      rsp_down_in   = rsp_down_ff;
      rsp_last_in   = rsp_last_ff;
      ctrl          = '0;
      ctrl.idx      = idx_ff;
      ctrl.macro_sel = macro_ff;
      case (state_ff)
         kprcd_pkg::ST_IDLE: begin
            if (accept) begin
               ctrl.capture = 1'b1;
               idx_in       = '0;
               macro_in     = (req_kind == kprcd_pkg::KIND_MACRO);
               if (req_kind == kprcd_pkg::KIND_MACRO ||
                   req_kind == kprcd_pkg::KIND_MODE_SOFT) begin
                  state_in = kprcd_pkg::ST_SCAN;
               end
            end
         end
         kprcd_pkg::ST_SCAN: begin
            if (!(changed && hold_valid_ff && !out_free)) begin
               if (changed) begin
                  ctrl.toggle = 1'b1;
                  if (hold_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_code_in  = hold_code_ff;
                     rsp_down_in  = hold_down_ff;
                     rsp_last_in  = 1'b0;
                  end
                  hold_valid_in = 1'b1;
                  hold_code_in  = result.code;
                  hold_down_in  = result.fresh;
               end
               idx_in = idx_ff + 1'b1;
               if (scan_end) begin
                  state_in = kprcd_pkg::ST_DRAIN;
               end
            end
         end
         kprcd_pkg::ST_DRAIN: begin
            if (!hold_valid_ff) begin
               state_in = kprcd_pkg::ST_IDLE;
            end else if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_code_in   = hold_code_ff;
               rsp_down_in   = hold_down_ff;
               rsp_last_in   = 1'b1;
               hold_valid_in = 1'b0;
               state_in      = kprcd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = kprcd_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_code   = rsp_code_ff;
   assign rsp_down   = rsp_down_ff;
   assign rsp_last   = rsp_last_ff;

   // no pending event survives into idle
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == kprcd_pkg::ST_IDLE) |-> !hold_valid_ff)
      else $error("pending event left in idle");

   // the final pending event leaves marked as last
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == kprcd_pkg::ST_DRAIN && hold_valid_ff && out_free) |=>
      (rsp_valid_ff && rsp_last_ff && state_ff == kprcd_pkg::ST_IDLE))
      else $error("last event not delivered");

   // scan index stays within the macro key range
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == kprcd_pkg::ST_SCAN) |->
      (idx_ff <= kprcd_pkg::IDX_W'(kprcd_pkg::MACRO_LAST)))
      else $error("scan index out of range");

   // a known report kind starts a scan from key zero
   assert property (@(posedge clock) disable iff (reset)
      (accept && (req_kind == kprcd_pkg::KIND_MACRO ||
                  req_kind == kprcd_pkg::KIND_MODE_SOFT)) |=>
      (state_ff == kprcd_pkg::ST_SCAN && idx_ff == '0))
      else $error("scan did not start");

endmodule

`default_nettype wire

// File: rtl/keypad_report_change_detector_unit.sv
`default_nettype none

// Keypad report change detector. Each accepted word is one eight-byte keypad
// report; a kind 1 report updates the 18 macro keys, a kind 2 report the 4
// mode keys and then the 5 soft keys, any other kind is dropped without
// output. Every key whose pressed state changed yields one result word in
// key order (event code = group base + key index, went_down, and tlast on the
// final event of the report). One shared compare/add unit examines one key
// per cycle unless a changed key meets a full output register, and the last
// event found is held back until the scan shows whether another follows. A
// report is accepted only in idle; its key scan and a drain state come before
// the return to idle, any other kind leaves the block in idle, and a full
// output register held off by the result side delays the scan or drain. Held
// key states clear at reset; base registers are written through the csr port.
module keypad_report_change_detector_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   // report words
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [63:0] req_tdata,  // report_byte_one .. report_byte_eight
   input  wire logic [7:0]  req_tuser,  // report_kind
   // event words
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,  // event_code
   output logic             rsp_tuser,  // went_down
   output logic             rsp_tlast,  // last_event
   // register writes
   input  wire logic        csr_we,
   input  wire logic [kprcd_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [7:0]  csr_wdata
);

   logic [7:0]  macro_base_ff, mode_base_ff, soft_base_ff;
   logic [63:0] report_ff, report_in;
   logic [kprcd_pkg::MACRO_KEYS-1:0] macro_pressed_ff, macro_pressed_in;
   logic [kprcd_pkg::MODE_KEYS-1:0]  mode_pressed_ff, mode_pressed_in;
   logic [kprcd_pkg::SOFT_KEYS-1:0]  soft_pressed_ff, soft_pressed_in;
   logic [kprcd_pkg::SOFT_IDX_W-1:0] soft_idx;
   kprcd_pkg::seq_ctrl_type   ctrl;
   kprcd_pkg::key_result_type result;

   // base registers
   always_ff @(posedge clock) begin
      if (reset) begin
         macro_base_ff <= kprcd_pkg::MACRO_BASE_RESET;
         mode_base_ff  <= kprcd_pkg::MODE_BASE_RESET;
         soft_base_ff  <= kprcd_pkg::SOFT_BASE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            kprcd_pkg::CSR_MACRO_BASE: macro_base_ff <= csr_wdata;
            kprcd_pkg::CSR_MODE_BASE:  mode_base_ff  <= csr_wdata;
            kprcd_pkg::CSR_SOFT_BASE:  soft_base_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign soft_idx = kprcd_pkg::SOFT_IDX_W'(ctrl.idx -
                     kprcd_pkg::IDX_W'(kprcd_pkg::MODE_KEYS));

   // report capture and held key state
   always_comb begin
      report_in        = ctrl.capture ? req_tdata : report_ff;
      macro_pressed_in = macro_pressed_ff;
      mode_pressed_in  = mode_pressed_ff;
      soft_pressed_in  = soft_pressed_ff;
      if (ctrl.toggle) begin
         if (ctrl.macro_sel) begin
            macro_pressed_in[ctrl.idx] = !macro_pressed_ff[ctrl.idx];
         end else if (ctrl.idx < kprcd_pkg::IDX_W'(kprcd_pkg::MODE_KEYS)) begin
            mode_pressed_in[ctrl.idx[kprcd_pkg::MODE_IDX_W-1:0]] =
               !mode_pressed_ff[ctrl.idx[kprcd_pkg::MODE_IDX_W-1:0]];
         end else begin
            soft_pressed_in[soft_idx] = !soft_pressed_ff[soft_idx];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         macro_pressed_ff <= '0;
         mode_pressed_ff  <= '0;
         soft_pressed_ff  <= '0;
      end else begin
         macro_pressed_ff <= macro_pressed_in;
         mode_pressed_ff  <= mode_pressed_in;
         soft_pressed_ff  <= soft_pressed_in;
      end
      report_ff <= report_in;
   end

   kprcd_key_unit u_key_unit (
      .macro_sel     (ctrl.macro_sel),
      .idx           (ctrl.idx),
      .report        (report_ff),
      .macro_base    (macro_base_ff),
      .mode_base     (mode_base_ff),
      .soft_base     (soft_base_ff),
      .macro_pressed (macro_pressed_ff),
      .mode_pressed  (mode_pressed_ff),
      .soft_pressed  (soft_pressed_ff),
      .result        (result)
   );

   kprcd_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_kind   (req_tuser),
      .result     (result),
      .ctrl       (ctrl),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_code   (rsp_tdata),
      .rsp_down   (rsp_tuser),
      .rsp_last   (rsp_tlast)
   );

endmodule

`default_nettype wire

// File: tb/keypad_report_change_detector_unit_tb.sv
`timescale 1ns / 1ps

module keypad_report_change_detector_unit_tb;

   localparam real        HALF_PERIOD  = 6.0;
   localparam int         LIMIT_CYCLES = 500000;
   localparam int         SETTLE       = 40;
   localparam logic [1:0] CSR_UNUSED   = 2'd3;

   // bit of each mode key (0..3) then soft key (0..4) within the packed report bytes
   localparam logic [71:0] KEY_BIT_POS =
      {8'd39, 8'd31, 8'd23, 8'd15, 8'd63, 8'd54, 8'd58, 8'd49, 8'd40};

   typedef struct packed {
      logic [7:0] code;
      logic       down;
      logic       is_last;
   } key_event_type;

   // key state tracker and expected event store
   class key_event_board_type;
      logic [7:0]    macro_base;
      logic [7:0]    mode_base;
      logic [7:0]    soft_base;
      logic [17:0]   macro_held;
      logic [3:0]    mode_held;
      logic [4:0]    soft_held;
      key_event_type expected_events[$];
      int            mismatches;

      function new();
         macro_base = kprcd_pkg::MACRO_BASE_RESET;
         mode_base  = kprcd_pkg::MODE_BASE_RESET;
         soft_base  = kprcd_pkg::SOFT_BASE_RESET;
         macro_held = '0;
         mode_held  = '0;
         soft_held  = '0;
         mismatches = 0;
      endfunction

      function void set_register(logic [1:0] idx, logic [7:0] value);
         case (idx)
            kprcd_pkg::CSR_MACRO_BASE: macro_base = value;
            kprcd_pkg::CSR_MODE_BASE:  mode_base  = value;
            kprcd_pkg::CSR_SOFT_BASE:  soft_base  = value;
            default: ;
         endcase
      endfunction

      function int pending();
         return expected_events.size();
      endfunction

      task report(string what);
         $display("mismatch at %0t: %s", $time, what);
         mismatches++;
      endtask

      // one event per key whose state differs, in key order
      function void queue_changes(logic [17:0] fresh, logic [17:0] held, int keys,
                                  logic [7:0] base);
         key_event_type ev;
         for (int k = 0; k < keys; k++) begin
            if (fresh[k] != held[k]) begin
               ev.code    = base + 8'(k);
               ev.down    = fresh[k];
               ev.is_last = 1'b0;
               expected_events.push_back(ev);
            end
         end
      endfunction

      // predict the events of one accepted report
      function void note_report(logic [7:0] kind, logic [63:0] bytes);
         logic [17:0]   fresh;
         logic [3:0]    mode_now;
         logic [4:0]    soft_now;
         logic [7:0]    key_code;
         int            first;
         key_event_type tail;
         first = expected_events.size();
         if (kind == kprcd_pkg::KIND_MACRO) begin
            fresh = '0;
            for (int i = 0; i < kprcd_pkg::MACRO_KEYS; i++) begin
               key_code = (i < kprcd_pkg::MACRO_LOW_KEYS) ?
                  kprcd_pkg::MACRO_CODE_LOW + 8'(i) :
                  kprcd_pkg::MACRO_CODE_HIGH + 8'(i - kprcd_pkg::MACRO_LOW_KEYS);
               // bytes 1 to 5 are the key code slots
               for (int j = 0; j < 5; j++)
                  if (bytes[8*j +: 8] == key_code)
                     fresh[i] = 1'b1;
            end
            queue_changes(fresh, macro_held, kprcd_pkg::MACRO_KEYS, macro_base);
            macro_held = fresh;
         end else if (kind == kprcd_pkg::KIND_MODE_SOFT) begin
            // mode: byte7 bit6, byte8 bit2, byte7 bit1, byte6 bit0
            mode_now = {bytes[54], bytes[58], bytes[49], bytes[40]};
            // soft: bit 7 of bytes 5, 4, 3, 2 and 8
            soft_now = {bytes[39], bytes[31], bytes[23], bytes[15], bytes[63]};
            queue_changes({14'b0, mode_now}, {14'b0, mode_held}, kprcd_pkg::MODE_KEYS,
                          mode_base);
            queue_changes({13'b0, soft_now}, {13'b0, soft_held}, kprcd_pkg::SOFT_KEYS,
                          soft_base);
            mode_held = mode_now;
            soft_held = soft_now;
         end
         if (expected_events.size() > first) begin
            tail = expected_events.pop_back();
            tail.is_last = 1'b1;
            expected_events.push_back(tail);
         end
      endfunction

      task check_event(logic [7:0] code, logic down, logic is_last);
         key_event_type want;
         if (expected_events.size() == 0) begin
            report($sformatf("unexpected event code %0d down %0b last %0b",
                             code, down, is_last));
         end else begin
            want = expected_events.pop_front();
            if (code !== want.code || down !== want.down || is_last !== want.is_last)
               report($sformatf("event code %0d down %0b last %0b, expected %0d %0b %0b",
                                code, down, is_last, want.code, want.down, want.is_last));
         end
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;  // report_byte_one .. report_byte_eight
   logic [7:0]  req_tuser;  // report_kind
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;  // event_code
   logic        rsp_tuser;  // went_down
   logic        rsp_tlast;  // last_event
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [7:0]  csr_wdata;

   key_event_board_type sb;
   bit                  tx_gaps;
   bit                  rx_gaps;
   int                  hold_request;
   int                  cycles;

   keypad_report_change_detector_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT_CYCLES) begin
         $display("keypad_report_change_detector_unit_tb NOT OK");
         $finish;
      end
   end

   // watch both channels; a report is noted before any event is checked
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            sb.note_report(req_tuser, req_tdata);
         if (rsp_tvalid && rsp_tready)
            sb.check_event(rsp_tdata, rsp_tuser, rsp_tlast);
      end
   end

   // event receiver: random stalls plus a requested long hold
   initial begin
      rsp_tready = 1'b0;
      forever begin
         if (hold_request > 0) begin
            rsp_tready <= 1'b0;
            repeat (hold_request) @(posedge clock);
            hold_request = 0;
         end else if (rx_gaps && $urandom_range(0, 2) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   end

   // offer one report word and wait for its handshake
   task send_report(logic [7:0] kind, logic [63:0] bytes);
      if (tx_gaps && $urandom_range(0, 2) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= bytes;
      do @(posedge clock); while (!req_tready);
   endtask

   // stop offering, wait for all events and for any report still in flight
   task drain_events();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   task write_register(logic [1:0] idx, logic [7:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      sb.set_register(idx, value);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task write_bases(logic [7:0] macro_b, logic [7:0] mode_b, logic [7:0] soft_b);
      write_register(kprcd_pkg::CSR_MACRO_BASE, macro_b);
      write_register(kprcd_pkg::CSR_MODE_BASE, mode_b);
      write_register(kprcd_pkg::CSR_SOFT_BASE, soft_b);
      write_register(CSR_UNUSED, 8'($urandom));
   endtask

   // macro report: slots mostly hold key codes, some zero or random
   function automatic logic [63:0] random_macro_report();
      logic [63:0] bytes;
      int          pick;
      int          roll;
      bytes = {$urandom, $urandom};
      for (int i = 0; i < 5; i++) begin
         roll = $urandom_range(0, 9);
         pick = $urandom_range(0, kprcd_pkg::MACRO_KEYS - 1);
         if (roll < 6)
            bytes[8*i +: 8] = (pick < kprcd_pkg::MACRO_LOW_KEYS) ?
               kprcd_pkg::MACRO_CODE_LOW + 8'(pick) :
               kprcd_pkg::MACRO_CODE_HIGH + 8'(pick - kprcd_pkg::MACRO_LOW_KEYS);
         else if (roll < 8)
            bytes[8*i +: 8] = 8'h00;
      end
      return bytes;
   endfunction

   // random reports; ignored kinds come on top of the count
   task run_random(int reports);
      int          sent;
      int          roll;
      logic [7:0]  kind;
      sent = 0;
      while (sent < reports) begin
         roll = $urandom_range(0, 99);
         if (roll < 12) begin
            do kind = 8'($urandom);
            while (kind == kprcd_pkg::KIND_MACRO || kind == kprcd_pkg::KIND_MODE_SOFT);
            send_report(kind, {$urandom, $urandom});
         end else if (roll < 55) begin
            send_report(kprcd_pkg::KIND_MACRO, random_macro_report());
            sent++;
         end else begin
            send_report(kprcd_pkg::KIND_MODE_SOFT, {$urandom, $urandom});
            sent++;
         end
      end
   endtask

   initial begin
      logic [63:0] walk;
      clock        = 1'b0;
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tuser    = '0;
      csr_we       = 1'b0;
      csr_index    = '0;
      csr_wdata    = '0;
      tx_gaps      = 1'b1;
      rx_gaps      = 1'b1;
      hold_request = 0;
      cycles       = 0;
      sb           = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed reports under the reset bases
      send_report(kprcd_pkg::KIND_MACRO, 64'h0);
      send_report(kprcd_pkg::KIND_MACRO, {24'hffffff, 40'h3e3d3c3b3a});
      send_report(kprcd_pkg::KIND_MACRO, {24'h000000, 40'h3a3b3c3d3e});
      // top low-range key, first and last high-range key, duplicate, non-key
      send_report(kprcd_pkg::KIND_MACRO, {24'h0, 40'h3923231e45});
      send_report(kprcd_pkg::KIND_MACRO, 64'hffffffffffffffff);
      send_report(kprcd_pkg::KIND_MODE_SOFT, 64'hffffffffffffffff);
      send_report(kprcd_pkg::KIND_MODE_SOFT, 64'hffffffffffffffff);
      send_report(kprcd_pkg::KIND_MODE_SOFT, 64'h0);
      // only bits that no key reads
      send_report(kprcd_pkg::KIND_MODE_SOFT, 64'h7bbdfe7f7f7f7fff);
      // one mode or soft key at a time
      for (int k = 0; k < kprcd_pkg::MODE_KEYS + kprcd_pkg::SOFT_KEYS; k++) begin
         walk = '0;
         walk[KEY_BIT_POS[8*k +: 8]] = 1'b1;
         send_report(kprcd_pkg::KIND_MODE_SOFT, walk);
      end
      send_report(kprcd_pkg::KIND_MODE_SOFT, 64'h0);
      send_report(8'h00, 64'hffffffffffffffff);
      send_report(8'h03, 64'hffffffffffffffff);
      send_report(8'hff, 64'hffffffffffffffff);
      drain_events();

      // low extreme
      write_bases(8'h00, 8'h00, 8'h00);
      run_random(30);
      drain_events();

      // high extreme, codes wrap; long receiver hold fills the block
      write_bases(8'hff, 8'hff, 8'hff);
      run_random(10);
      tx_gaps      = 1'b0;
      hold_request = 400;
      for (int n = 0; n < 20; n++)
         send_report(kprcd_pkg::KIND_MACRO, random_macro_report());
      tx_gaps = 1'b1;
      drain_events();

      write_bases(8'($urandom), 8'($urandom), 8'($urandom));
      run_random(30);
      drain_events();

      // near the wrap point
      write_bases(8'd250, 8'd254, 8'd252);
      run_random(30);
      drain_events();

      // last part without idling
      write_bases(8'($urandom), 8'($urandom), 8'($urandom));
      tx_gaps = 1'b0;
      rx_gaps = 1'b0;
      run_random(30);
      drain_events();

      if (sb.mismatches == 0)
         $display("keypad_report_change_detector_unit_tb OK");
      else
         $display("keypad_report_change_detector_unit_tb NOT OK");
      $finish;
   end

endmodule
